// ----- src/rrb_pkg.sv -----
// Shared types and filter constants for the RGB row blur block.
`timescale 1ns / 1ps

package rrb_pkg;

    // One color channel and one packed pixel (lane 0 red, 1 green, 2 blue)
    typedef logic [7:0] chan_t;
    typedef logic [2:0][7:0] pixel_t;

    localparam int unsigned NUM_LANES = 3;

    // Filter weights, Q7 fixed point
    localparam logic [7:0] WT_SIDE      = 8'h10;
    localparam logic [7:0] WT_CENTER    = 8'h60;
    localparam logic [7:0] WT_EDGE_SIDE = 8'h20;
    localparam int unsigned Q_SHIFT     = 7;
    localparam logic [7:0] PIX_MAX      = 8'hFF;

    // Position within the current row
    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_ONE,
        SEEN_MANY
    } seen_t;

    // One result item as queued for the output channel
    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  row_end;
        logic  run_last;
    } res_t;

endpackage

// ----- src/rrb_if.sv -----
// Valid/ready channel interfaces for the row blur pixel input and output.
`timescale 1ns / 1ps

interface rrb_in_if;
    logic          valid;
    logic          ready;
    rrb_pkg::chan_t red_in;
    rrb_pkg::chan_t green_in;
    rrb_pkg::chan_t blue_in;
    logic          row_end_in;

    modport source (output valid, red_in, green_in, blue_in, row_end_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, row_end_in, output ready);
endinterface

interface rrb_out_if;
    logic          valid;
    logic          ready;
    rrb_pkg::chan_t red_out;
    rrb_pkg::chan_t green_out;
    rrb_pkg::chan_t blue_out;
    logic          row_end_out;
    logic          run_last;

    modport source (output valid, red_out, green_out, blue_out, row_end_out, run_last,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, row_end_out, run_last,
                    output ready);
endinterface

// ----- src/rrb_lane.sv -----
// One channel lane: weighted 3-tap sums for the pending and the row-end pixel.
`timescale 1ns / 1ps

module rrb_lane (
    input  rrb_pkg::chan_t older,
    input  rrb_pkg::chan_t newer,
    input  rrb_pkg::chan_t cur,
    input  logic           seen_one,
    output rrb_pkg::chan_t held,
    output rrb_pkg::chan_t last
);
    import rrb_pkg::*;

    logic [15:0] held_acc;
    logic [15:0] last_acc;

    // Shift out the fraction and saturate to the pixel range
    function automatic chan_t sat8(input logic [15:0] acc);
        logic [8:0] sh;
        sh = 9'(acc >> Q_SHIFT);
        if (sh > {1'b0, PIX_MAX})
            return PIX_MAX;
        return sh[7:0];
    endfunction

    // Pending pixel: left edge when only one pixel is held, interior otherwise
    always_comb
    begin
        if (seen_one)
        begin
            held_acc = 16'(newer) * 16'(WT_CENTER) + 16'(cur) * 16'(WT_EDGE_SIDE);
        end
        else
        begin
            held_acc = 16'(older) * 16'(WT_SIDE) + 16'(newer) * 16'(WT_CENTER)
                     + 16'(cur) * 16'(WT_SIDE);
        end
    end

    // Right edge pixel of the row
    assign last_acc = 16'(newer) * 16'(WT_EDGE_SIDE) + 16'(cur) * 16'(WT_CENTER);

    assign held = sat8(held_acc);
    assign last = sat8(last_acc);

endmodule

// ----- src/rrb_res_fifo.sv -----
// Result queue that takes up to two results per cycle and drains one per cycle while popped.
`timescale 1ns / 1ps

module rrb_res_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push0,
    input  rrb_pkg::res_t  data0,
    input  logic           push1,
    input  rrb_pkg::res_t  data1,
    output logic           space_two,
    output logic           head_valid,
    output rrb_pkg::res_t  head,
    input  logic           pop
);
    import rrb_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    res_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] wr_ptr_plus;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1))
            return '0;
        return p + AW'(1);
    endfunction

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign space_two  = (count_reg <= CW'(DEPTH - 2));
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_plus = ptr_inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        if (push0 && push1)
            wr_ptr_next = ptr_inc(wr_ptr_plus);
        else if (push0)
            wr_ptr_next = wr_ptr_plus;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push0) + CW'(push0 && push1) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the requests in arrival order
    always_ff @(posedge clk)
    begin
        if (push0)
            mem_reg[wr_ptr_reg] <= data0;
        if (push0 && push1)
            mem_reg[wr_ptr_plus] <= data1;
    end

endmodule

// ----- src/rgb_row_blur_3tap_core.sv -----
// Top level of the horizontal 3-tap RGB row blur.
`timescale 1ns / 1ps

// Usage:
//   pixels_in carries one RGB pixel per request, in row order, with row_end_in
//   set on the last pixel of each row. pixels_out carries filtered pixels with
//   row_end_out on the last pixel of a row and run_last on the last result
//   caused by an input request.
//   Each pixel is emitted when its right neighbor arrives; the request that
//   completes it writes its result into the queue. The first pixel of a row
//   gives no result; a row-end pixel gives two (one if the row has one pixel).
//   Three channel lanes compute the sums side by side combinationally;
//   results go into a small queue that drains one per cycle while the
//   receiver is ready. Throughput is one pixel per cycle; input ready drops
//   only while the queue cannot take two more results, which a stalled
//   receiver causes after RES_DEPTH-1 results back up.
//   Reset empties the queue and starts a new row. When the receiver stalls,
//   results wait in the queue and input ready falls once it nears full.
module rgb_row_blur_3tap_core #(
    parameter int unsigned RES_DEPTH = 4
) (
    input  logic  clk,
    input  logic  rst_n,
    rrb_in_if.sink    pixels_in,
    rrb_out_if.source pixels_out
);
    import rrb_pkg::*;

    seen_t   seen_reg;
    seen_t   seen_next;
    pixel_t  older_reg;
    pixel_t  older_next;
    pixel_t  newer_reg;
    pixel_t  newer_next;
    pixel_t  cur;
    pixel_t  held_pix;
    pixel_t  last_pix;
    logic    accept;
    logic    row_end;
    logic    space_two;
    logic    push0;
    logic    push1;
    res_t    data0;
    res_t    data1;
    res_t    head;

    assign cur[0]  = pixels_in.red_in;
    assign cur[1]  = pixels_in.green_in;
    assign cur[2]  = pixels_in.blue_in;
    assign row_end = pixels_in.row_end_in;

    assign pixels_in.ready = space_two;
    assign accept          = pixels_in.valid && space_two;

    // Channel lanes
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        rrb_lane u_lane (
            .older    (older_reg[g]),
            .newer    (newer_reg[g]),
            .cur      (cur[g]),
            .seen_one (seen_reg == SEEN_ONE),
            .held     (held_pix[g]),
            .last     (last_pix[g])
        );
    end

    // Next row position
    always_comb
    begin
        seen_next = seen_reg;
        case (seen_reg)
            SEEN_NONE:
            begin
                if (accept && !row_end)
                    seen_next = SEEN_ONE;
            end
            default:
            begin
                if (accept)
                    seen_next = row_end ? SEEN_NONE : SEEN_MANY;
            end
        endcase
    end

    // Merge lane results into result requests
    always_comb
    begin
        push0 = 1'b0;
        push1 = 1'b0;
        data0 = '{red: held_pix[0], green: held_pix[1], blue: held_pix[2],
                  row_end: 1'b0, run_last: !row_end};
        data1 = '{red: last_pix[0], green: last_pix[1], blue: last_pix[2],
                  row_end: 1'b1, run_last: 1'b1};
        case (seen_reg)
            SEEN_NONE:
            begin
                push0 = accept && row_end;
                data0 = '{red: cur[0], green: cur[1], blue: cur[2],
                          row_end: 1'b1, run_last: 1'b1};
            end
            default:
            begin
                push0 = accept;
                push1 = accept && row_end;
            end
        endcase
    end

    // Shift the pixel window on every request that does not end the row
    always_comb
    begin
        older_next = older_reg;
        newer_next = newer_reg;
        if (accept && !row_end)
        begin
            older_next = newer_reg;
            newer_next = cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= SEEN_NONE;
        else
            seen_reg <= seen_next;
    end

    always_ff @(posedge clk)
    begin
        older_reg <= older_next;
        newer_reg <= newer_next;
    end

    rrb_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (push0),
        .data0      (data0),
        .push1      (push1),
        .data1      (data1),
        .space_two  (space_two),
        .head_valid (pixels_out.valid),
        .head       (head),
        .pop        (pixels_out.ready)
    );

    assign pixels_out.red_out     = head.red;
    assign pixels_out.green_out   = head.green;
    assign pixels_out.blue_out    = head.blue;
    assign pixels_out.row_end_out = head.row_end;
    assign pixels_out.run_last    = head.run_last;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the RGB row blur: directed rows, then random rows under flow control.
`timescale 1ns / 1ps

module tb;
    import rrb_pkg::*;

    // One row of the directed table; n_typed < 0 means the result comes from the predictor
    typedef struct {
        pixel_t px;
        logic   row_end;
        int     n_typed;
        res_t   t0;
        res_t   t1;
    } stim_row_t;

    logic clk;
    logic rst_n;

    rrb_in_if  pix_in ();
    rrb_out_if pix_out ();

    rgb_row_blur_3tap_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels_in  (pix_in),
        .pixels_out (pix_out)
    );

    // Predictor state: the two most recent pixels and the position in the row
    pixel_t row_older;
    pixel_t row_newer;
    seen_t  row_seen;

    res_t blur_expect_q[$];
    int   fail_count;
    int   tx_idle_pct;
    int   rx_stall_pct;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Weighted three-tap sum of one channel, shifted down and clamped
    function automatic chan_t tap3(chan_t a, logic [7:0] wa, chan_t b, logic [7:0] wb,
                                   chan_t c, logic [7:0] wc);
        logic [17:0] acc;
        acc = a * wa + b * wb + c * wc;
        acc = acc >> Q_SHIFT;
        if (acc > PIX_MAX)
        begin
            acc = PIX_MAX;
        end
        return acc[7:0];
    endfunction

    function automatic pixel_t blend(pixel_t a, logic [7:0] wa, pixel_t b, logic [7:0] wb,
                                     pixel_t c, logic [7:0] wc);
        pixel_t p;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            p[k] = tap3(a[k], wa, b[k], wb, c[k], wc);
        end
        return p;
    endfunction

    function automatic res_t mk_res(pixel_t p, logic row_end, logic run_last);
        res_t r;
        r.red      = p[0];
        r.green    = p[1];
        r.blue     = p[2];
        r.row_end  = row_end;
        r.run_last = run_last;
        return r;
    endfunction

    // Advance the row state by one pixel; return how many blurred pixels it releases
    function automatic int blur_step(input pixel_t px, input logic row_end,
                                     output res_t r0, output res_t r1);
        pixel_t held;
        r0 = '0;
        r1 = '0;
        if (row_seen == SEEN_NONE)
        begin
            if (row_end)
            begin
                r0 = mk_res(px, 1'b1, 1'b1);
                return 1;
            end
            row_newer = px;
            row_seen  = SEEN_ONE;
            return 0;
        end
        if (row_seen == SEEN_ONE)
        begin
            held = blend(row_newer, WT_CENTER, px, WT_EDGE_SIDE, '0, 8'h00);
        end
        else
        begin
            held = blend(row_older, WT_SIDE, row_newer, WT_CENTER, px, WT_SIDE);
        end
        if (row_end)
        begin
            r0 = mk_res(held, 1'b0, 1'b0);
            r1 = mk_res(blend(row_newer, WT_EDGE_SIDE, px, WT_CENTER, '0, 8'h00),
                        1'b1, 1'b1);
            row_seen = SEEN_NONE;
            return 2;
        end
        r0 = mk_res(held, 1'b0, 1'b1);
        row_older = row_newer;
        row_newer = px;
        row_seen  = SEEN_MANY;
        return 1;
    endfunction

    // Offer one pixel request, hold it until accepted, then queue its expected results
    task automatic push_pixel(input stim_row_t row);
        res_t r0;
        res_t r1;
        int   n;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.red_in     <= row.px[0];
        pix_in.green_in   <= row.px[1];
        pix_in.blue_in    <= row.px[2];
        pix_in.row_end_in <= row.row_end;
        do
            @(posedge clk);
        while (!pix_in.ready);
        n = blur_step(row.px, row.row_end, r0, r1);
        if (row.n_typed >= 0)
        begin
            n  = row.n_typed;
            r0 = row.t0;
            r1 = row.t1;
        end
        if (n > 0)
        begin
            blur_expect_q.push_back(r0);
        end
        if (n > 1)
        begin
            blur_expect_q.push_back(r1);
        end
    endtask

    // Hold the sender until every expected result has drained
    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        while (blur_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        if ($urandom_range(7) == 0)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                p[k] = {8{1'($urandom_range(1))}};
            end
        end
        else
        begin
            p = 24'($urandom);
        end
        return p;
    endfunction

    // Send whole random rows until the phase has used its share of pixels
    task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct);
        stim_row_t row;
        int        row_len;
        int        sel;
        int        sent;
        wait_drained();
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < n_items)
        begin
            sel = $urandom_range(9);
            if (sel == 0)
            begin
                row_len = 1;
            end
            else if (sel == 1)
            begin
                row_len = 2;
            end
            else if (sel == 9)
            begin
                row_len = $urandom_range(48, 13);
            end
            else
            begin
                row_len = $urandom_range(12, 3);
            end
            for (int i = 0; i < row_len; i++)
            begin
                row.px      = rand_pixel();
                row.row_end = (i == row_len - 1);
                row.n_typed = -1;
                row.t0      = '0;
                row.t1      = '0;
                push_pixel(row);
            end
            sent += row_len;
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Check each accepted result against the oldest expectation, then pick the next stall
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (blur_expect_q.size() == 0)
            begin
                $error("unexpected result: red %0d green %0d blue %0d",
                       pix_out.red_out, pix_out.green_out, pix_out.blue_out);
                fail_count++;
            end
            else
            begin
                want = blur_expect_q.pop_front();
                check_field("red_out", want.red, pix_out.red_out);
                check_field("green_out", want.green, pix_out.green_out);
                check_field("blue_out", want.blue, pix_out.blue_out);
                check_field("row_end_out", want.row_end, pix_out.row_end_out);
                check_field("run_last", want.run_last, pix_out.run_last);
            end
        end
        pix_out.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Main sequence: reset, directed table, four flow-control phases, drain
    initial
    begin
        stim_row_t dir_table[$];
        res_t      ff_mid;
        res_t      ff_end;
        res_t      ff_lead;
        res_t      zero_mid;
        res_t      zero_end;

        row_older    = '0;
        row_newer    = '0;
        row_seen     = SEEN_NONE;
        fail_count   = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;

        rst_n             <= 1'b0;
        pix_in.valid      <= 1'b0;
        pix_in.red_in     <= '0;
        pix_in.green_in   <= '0;
        pix_in.blue_in    <= '0;
        pix_in.row_end_in <= 1'b0;

        ff_mid   = mk_res(24'hFFFFFF, 1'b0, 1'b0);
        ff_end   = mk_res(24'hFFFFFF, 1'b1, 1'b1);
        ff_lead  = mk_res(24'hFFFFFF, 1'b0, 1'b1);
        zero_mid = mk_res(24'h000000, 1'b0, 1'b0);
        zero_end = mk_res(24'h000000, 1'b1, 1'b1);

        // One-pixel rows copy through unchanged (pixel packs blue, green, red)
        dir_table.push_back(stim_row_t'{24'h563412, 1'b1, 1,
                                        mk_res(24'h563412, 1'b1, 1'b1), '0});
        dir_table.push_back(stim_row_t'{24'h000000, 1'b1, 1, zero_end, '0});
        dir_table.push_back(stim_row_t'{24'hFFFFFF, 1'b1, 1, ff_end, '0});
        // Two-pixel rows at both extremes: row start gives nothing, row end gives two
        dir_table.push_back(stim_row_t'{24'hFFFFFF, 1'b0, 0, '0, '0});
        dir_table.push_back(stim_row_t'{24'hFFFFFF, 1'b1, 2, ff_mid, ff_end});
        dir_table.push_back(stim_row_t'{24'h000000, 1'b0, 0, '0, '0});
        dir_table.push_back(stim_row_t'{24'h000000, 1'b1, 2, zero_mid, zero_end});
        // Three full-scale pixels: first-pixel, interior and last-pixel weights all give 255
        dir_table.push_back(stim_row_t'{24'hFFFFFF, 1'b0, 0, '0, '0});
        dir_table.push_back(stim_row_t'{24'hFFFFFF, 1'b0, 1, ff_lead, '0});
        dir_table.push_back(stim_row_t'{24'hFFFFFF, 1'b1, 2, ff_mid, ff_end});
        // Mixed five-pixel row
        dir_table.push_back(stim_row_t'{24'h00FF00, 1'b0, -1, '0, '0});
        dir_table.push_back(stim_row_t'{24'hFF00FF, 1'b0, -1, '0, '0});
        dir_table.push_back(stim_row_t'{24'h017F80, 1'b0, -1, '0, '0});
        dir_table.push_back(stim_row_t'{24'hFE0201, 1'b0, -1, '0, '0});
        dir_table.push_back(stim_row_t'{24'h33AA55, 1'b1, -1, '0, '0});
        // Alternating black and white, hardest edges for every tap
        dir_table.push_back(stim_row_t'{24'hFFFFFF, 1'b0, -1, '0, '0});
        dir_table.push_back(stim_row_t'{24'h000000, 1'b0, -1, '0, '0});
        dir_table.push_back(stim_row_t'{24'hFFFFFF, 1'b0, -1, '0, '0});
        dir_table.push_back(stim_row_t'{24'h000000, 1'b0, -1, '0, '0});
        dir_table.push_back(stim_row_t'{24'hFFFFFF, 1'b1, -1, '0, '0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
        begin
            push_pixel(dir_table[i]);
        end

        run_phase(335, 0, 0);
        run_phase(335, 73, 0);
        run_phase(335, 0, 73);
        run_phase(335, 6, 6);

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake
    initial
    begin
        #5000000;
        $display("tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/rrb_pkg.sv
src/rrb_if.sv
src/rrb_lane.sv
src/rrb_res_fifo.sv
src/rgb_row_blur_3tap_core.sv
bench/tb.sv
